// ===== rtl/kvt_pkg.sv =====
// Package for the keyframe vertex transform: payload types and normal ROM.
`default_nettype none
package kvt_pkg;

    typedef struct packed {
        logic signed [23:0] first_x;
        logic signed [23:0] first_y;
        logic signed [23:0] first_z;
        logic signed [23:0] second_x;
        logic signed [23:0] second_y;
        logic signed [23:0] second_z;
        logic [7:0]         first_normal;
        logic [7:0]         second_normal;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [7:0]         chosen_normal;
    } t_out_item;

    typedef enum logic [2:0] {
        REG_SCALE_PAIR = 3'd0,
        REG_Z_BIAS     = 3'd1,
        REG_PITCH      = 3'd2,
        REG_YAW        = 3'd3,
        REG_ORIGIN_X   = 3'd4,
        REG_ORIGIN_Y   = 3'd5,
        REG_ORIGIN_Z   = 3'd6,
        REG_BLEND      = 3'd7
    } t_reg_idx;

    localparam int RomSize = 162;

    localparam logic signed [15:0] C000 = 16'sd0;
    localparam logic signed [15:0] C147 = 16'sd2419;
    localparam logic signed [15:0] C162 = 16'sd2662;
    localparam logic signed [15:0] C238 = 16'sd3913;
    localparam logic signed [15:0] C262 = 16'sd4307;
    localparam logic signed [15:0] C295 = 16'sd4837;
    localparam logic signed [15:0] C309 = 16'sd5063;
    localparam logic signed [15:0] C425 = 16'sd6969;
    localparam logic signed [15:0] C442 = 16'sd7256;
    localparam logic signed [15:0] C500 = 16'sd8192;
    localparam logic signed [15:0] C525 = 16'sd8614;
    localparam logic signed [15:0] C587 = 16'sd9630;
    localparam logic signed [15:0] C681 = 16'sd11169;
    localparam logic signed [15:0] C688 = 16'sd11275;
    localparam logic signed [15:0] C716 = 16'sd11740;
    localparam logic signed [15:0] C809 = 16'sd13255;
    localparam logic signed [15:0] C850 = 16'sd13937;
    localparam logic signed [15:0] C864 = 16'sd14159;
    localparam logic signed [15:0] C951 = 16'sd15582;
    localparam logic signed [15:0] C955 = 16'sd15654;
    localparam logic signed [15:0] C1000 = 16'sd16384;

    typedef logic signed [15:0] t_vec3 [3];

    localparam logic signed [15:0] NormalRom [RomSize][3] = '{
'{-C525,C000,C850},'{-C442,C238,C864},'{-C295,C000,C955},'{-C309,C500,C809},
'{-C162,C262,C951},'{C000,C000,C1000},'{C000,C850,C525},'{-C147,C716,C681},
'{C147,C716,C681},'{C000,C525,C850},'{C309,C500,C809},'{C525,C000,C850},
'{C295,C000,C955},'{C442,C238,C864},'{C162,C262,C951},'{-C681,C147,C716},
'{-C809,C309,C500},'{-C587,C425,C688},'{-C850,C525,C000},'{-C864,C442,C238},
'{-C716,C681,C147},'{-C688,C587,C425},'{-C500,C809,C309},'{-C238,C864,C442},
'{-C425,C688,C587},'{-C716,C681,-C147},'{-C500,C809,-C309},'{-C525,C850,C000},
'{C000,C850,-C525},'{-C238,C864,-C442},'{C000,C955,-C295},'{-C262,C951,-C162},
'{C000,C1000,C000},'{C000,C955,C295},'{-C262,C951,C162},'{C238,C864,C442},
'{C262,C951,C162},'{C500,C809,C309},'{C238,C864,-C442},'{C262,C951,-C162},
'{C500,C809,-C309},'{C850,C525,C000},'{C716,C681,C147},'{C716,C681,-C147},
'{C525,C850,C000},'{C425,C688,C587},'{C864,C442,C238},'{C688,C587,C425},
'{C809,C309,C500},'{C681,C147,C716},'{C587,C425,C688},'{C955,C295,C000},
'{C1000,C000,C000},'{C951,C162,C262},'{C850,-C525,C000},'{C955,-C295,C000},
'{C864,-C442,C238},'{C951,-C162,C262},'{C809,-C309,C500},'{C681,-C147,C716},
'{C850,C000,C525},'{C864,C442,-C238},'{C809,C309,-C500},'{C951,C162,-C262},
'{C525,C000,-C850},'{C681,C147,-C716},'{C681,-C147,-C716},'{C850,C000,-C525},
'{C809,-C309,-C500},'{C864,-C442,-C238},'{C951,-C162,-C262},'{C147,C716,-C681},
'{C309,C500,-C809},'{C425,C688,-C587},'{C442,C238,-C864},'{C587,C425,-C688},
'{C688,C587,-C425},'{-C147,C716,-C681},'{-C309,C500,-C809},'{C000,C525,-C850},
'{-C525,C000,-C850},'{-C442,C238,-C864},'{-C295,C000,-C955},'{-C162,C262,-C951},
'{C000,C000,-C1000},'{C295,C000,-C955},'{C162,C262,-C951},'{-C442,-C238,-C864},
'{-C309,-C500,-C809},'{-C162,-C262,-C951},'{C000,-C850,-C525},'{-C147,-C716,-C681},
'{C147,-C716,-C681},'{C000,-C525,-C850},'{C309,-C500,-C809},'{C442,-C238,-C864},
'{C162,-C262,-C951},'{C238,-C864,-C442},'{C500,-C809,-C309},'{C425,-C688,-C587},
'{C716,-C681,-C147},'{C688,-C587,-C425},'{C587,-C425,-C688},'{C000,-C955,-C295},
'{C000,-C1000,C000},'{C262,-C951,-C162},'{C000,-C850,C525},'{C000,-C955,C295},
'{C238,-C864,C442},'{C262,-C951,C162},'{C500,-C809,C309},'{C716,-C681,C147},
'{C525,-C850,C000},'{-C238,-C864,-C442},'{-C500,-C809,-C309},'{-C262,-C951,-C162},
'{-C850,-C525,C000},'{-C716,-C681,-C147},'{-C716,-C681,C147},'{-C525,-C850,C000},
'{-C500,-C809,C309},'{-C238,-C864,C442},'{-C262,-C951,C162},'{-C864,-C442,C238},
'{-C809,-C309,C500},'{-C688,-C587,C425},'{-C681,-C147,C716},'{-C442,-C238,C864},
'{-C587,-C425,C688},'{-C309,-C500,C809},'{-C147,-C716,C681},'{-C425,-C688,C587},
'{-C162,-C262,C951},'{C442,-C238,C864},'{C162,-C262,C951},'{C309,-C500,C809},
'{C147,-C716,C681},'{C000,-C525,C850},'{C425,-C688,C587},'{C587,-C425,C688},
'{C688,-C587,C425},'{-C955,C295,C000},'{-C951,C162,C262},'{-C1000,C000,C000},
'{-C850,C000,C525},'{-C955,-C295,C000},'{-C951,-C162,C262},'{-C864,C442,-C238},
'{-C951,C162,-C262},'{-C809,C309,-C500},'{-C864,-C442,-C238},'{-C951,-C162,-C262},
'{-C809,-C309,-C500},'{-C681,C147,-C716},'{-C681,-C147,-C716},'{-C850,C000,-C525},
'{-C688,C587,-C425},'{-C587,C425,-C688},'{-C425,C688,-C587},'{-C425,-C688,-C587},
'{-C587,-C425,-C688},'{-C688,-C587,-C425}
    };

endpackage
`default_nettype wire

// ===== rtl/keyframe_vertex_transform.sv =====
// Throughput: one vertex per cycle; every stage advances whenever the
// output register is free or being drained (a global pipeline enable).
// Reset clears the stage valid bits and loads the register defaults:
// scales 1.0, pitch/yaw word 16384 (p0/y0 = 1.0), zero bias/origin/weight.
// Stage work: S1 scale, S2 pitch, S3 yaw, S4 origin, S5 blend products,
// S6 blend sum, S7 output register.
`default_nettype none
module keyframe_vertex_transform #(
    parameter int NORMAL_COUNT = 162
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [2:0]            i_cfg_idx,
    input  wire [63:0]           i_cfg_data,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  kvt_pkg::t_in_item    i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output kvt_pkg::t_out_item   o_data
);
    import kvt_pkg::*;

    localparam int Stages = 7;

    // configuration registers
    logic [31:0]        r_scale;
    logic signed [23:0] r_zbias;
    logic [63:0]        r_pitch, r_yaw;
    logic signed [31:0] r_ox, r_oy, r_oz;
    logic [16:0]        r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 32'h0100_0100;
            r_zbias <= '0;
            r_pitch <= 64'd16384;
            r_yaw   <= 64'd16384;
            r_ox    <= '0;
            r_oy    <= '0;
            r_oz    <= '0;
            r_w     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SCALE_PAIR: r_scale <= i_cfg_data[31:0];
                REG_Z_BIAS:     r_zbias <= i_cfg_data[23:0];
                REG_PITCH:      r_pitch <= i_cfg_data;
                REG_YAW:        r_yaw   <= i_cfg_data;
                REG_ORIGIN_X:   r_ox    <= i_cfg_data[31:0];
                REG_ORIGIN_Y:   r_oy    <= i_cfg_data[31:0];
                REG_ORIGIN_Z:   r_oz    <= i_cfg_data[31:0];
                REG_BLEND:      r_w     <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // derived constants of the configuration
    logic signed [17:0] sxy, sz;
    logic signed [15:0] p0, p1, p2, p3, y0, y1c, y2, y3;
    logic [16:0]        w_sat;
    logic signed [17:0] w_s, wc_s;
    assign sxy = {2'b00, r_scale[15:0]};
    assign sz  = {2'b00, r_scale[31:16]};
    assign p0 = r_pitch[15:0];
    assign p1 = r_pitch[31:16];
    assign p2 = r_pitch[47:32];
    assign p3 = r_pitch[63:48];
    assign y0 = r_yaw[15:0];
    assign y1c = r_yaw[31:16];
    assign y2 = r_yaw[47:32];
    assign y3 = r_yaw[63:48];
    assign w_sat = (r_w > 17'd65536) ? 17'd65536 : r_w;
    assign w_s  = {1'b0, w_sat};
    assign wc_s = 18'sd65536 - w_s;

    // pipeline control
    logic [Stages-1:0] r_vld;
    logic              en;
    assign en = !r_vld[Stages-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[Stages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Stages-2:0], i_valid};
        end
    end

    // S1: scale and normal ROM lookup (two frames, index 0 first, 1 second)
    logic signed [33:0] r1_x [2], r1_y [2], r1_z [2];
    logic signed [15:0] r1_nx, r1_ny, r1_nz;
    logic [7:0]         r1_idx;
    logic signed [23:0] in_x [2], in_y [2], in_z [2];
    logic signed [41:0] n_sx [2], n_sy [2], n_sz [2];
    logic [7:0]         sel_idx;

    assign in_x[0] = i_data.first_x;
    assign in_y[0] = i_data.first_y;
    assign in_z[0] = i_data.first_z;
    assign in_x[1] = i_data.second_x;
    assign in_y[1] = i_data.second_y;
    assign in_z[1] = i_data.second_z;
    assign sel_idx = w_sat[16:15] == 2'b00 ? i_data.first_normal : i_data.second_normal;

    always_comb begin
        for (int f = 0; f < 2; f++) begin
            n_sx[f] = 42'(in_x[f]) * 42'(sxy);
            n_sy[f] = 42'(in_y[f]) * 42'(sxy);
            n_sz[f] = (42'(in_z[f]) + 42'(r_zbias)) * 42'(sz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int f = 0; f < 2; f++) begin
                r1_x[f] <= n_sx[f][41:8];
                r1_y[f] <= n_sy[f][41:8];
                r1_z[f] <= n_sz[f][41:8];
            end
            r1_idx <= sel_idx;
            if (32'(sel_idx) < NORMAL_COUNT && 32'(sel_idx) < RomSize) begin
                r1_nx <= NormalRom[sel_idx][0];
                r1_ny <= NormalRom[sel_idx][1];
                r1_nz <= NormalRom[sel_idx][2];
            end else begin
                r1_nx <= '0;
                r1_ny <= '0;
                r1_nz <= '0;
            end
        end
    end

    // S2: pitch. Lane 2 is the normal.
    logic signed [33:0] a_x [3], a_y [3], a_z [3];
    logic signed [34:0] r2_x [3], r2_z [3];
    logic signed [33:0] r2_y [3];
    logic [7:0]         r2_idx;
    logic signed [50:0] n_px [3], n_pz [3];

    always_comb begin
        for (int f = 0; f < 2; f++) begin
            a_x[f] = r1_x[f];
            a_y[f] = r1_y[f];
            a_z[f] = r1_z[f];
        end
        a_x[2] = 34'(r1_nx);
        a_y[2] = 34'(r1_ny);
        a_z[2] = 34'(r1_nz);
        for (int f = 0; f < 3; f++) begin
            n_px[f] = 51'(a_x[f]) * 51'(p0) + 51'(a_z[f]) * 51'(p1);
            n_pz[f] = 51'(a_x[f]) * 51'(p2) + 51'(a_z[f]) * 51'(p3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int f = 0; f < 3; f++) begin
                r2_x[f] <= n_px[f][48:14];
                r2_z[f] <= n_pz[f][48:14];
                r2_y[f] <= a_y[f];
            end
            r2_idx <= r1_idx;
        end
    end

    // S3: yaw
    logic signed [35:0] r3_x [3], r3_y [3];
    logic signed [34:0] r3_z [3];
    logic [7:0]         r3_idx;
    logic signed [51:0] n_yx [3], n_yy [3];

    always_comb begin
        for (int f = 0; f < 3; f++) begin
            n_yx[f] = 52'(r2_x[f]) * 52'(y0) + 52'(r2_y[f]) * 52'(y1c);
            n_yy[f] = 52'(r2_x[f]) * 52'(y2) + 52'(r2_y[f]) * 52'(y3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int f = 0; f < 3; f++) begin
                r3_x[f] <= n_yx[f][49:14];
                r3_y[f] <= n_yy[f][49:14];
                r3_z[f] <= r2_z[f];
            end
            r3_idx <= r2_idx;
        end
    end

    // S4: origin add, normal saturation
    logic signed [36:0] r4_p [2][3];
    logic signed [15:0] r4_n [3];
    logic [7:0]         r4_idx;

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        logic signed [15:0] r;
        if (v > 36'sd32767) r = 16'sd32767;
        else if (v < -36'sd32768) r = -16'sd32768;
        else r = v[15:0];
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int f = 0; f < 2; f++) begin
                r4_p[f][0] <= 37'(r_ox) + 37'(r3_x[f]);
                r4_p[f][1] <= 37'(r_oy) + 37'(r3_y[f]);
                r4_p[f][2] <= 37'(r_oz) + 37'(r3_z[f]);
            end
            r4_n[0] <= sat16(r3_x[2]);
            r4_n[1] <= sat16(r3_y[2]);
            r4_n[2] <= sat16(36'(r3_z[2]));
            r4_idx  <= r3_idx;
        end
    end

    // S5: blend products (37 x 18 each)
    logic signed [55:0] r5_a [3], r5_b [3];
    logic signed [15:0] r5_n [3];
    logic [7:0]         r5_idx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r5_a[k] <= 56'(r4_p[0][k]) * 56'(wc_s);
                r5_b[k] <= 56'(r4_p[1][k]) * 56'(w_s);
                r5_n[k] <= r4_n[k];
            end
            r5_idx <= r4_idx;
        end
    end

    // S6: blend sum and shift; wraps to 32 bits
    logic signed [31:0] r6_p [3];
    logic signed [15:0] r6_n [3];
    logic [7:0]         r6_idx;
    logic signed [55:0] n_sum [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = r5_a[k] + r5_b[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r6_p[k] <= n_sum[k][47:16];
                r6_n[k] <= r5_n[k];
            end
            r6_idx <= r5_idx;
        end
    end

    // S7: output register
    t_out_item r_out;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.pos_x <= r6_p[0];
            r_out.pos_y <= r6_p[1];
            r_out.pos_z <= r6_p[2];
            r_out.norm_x <= r6_n[0];
            r_out.norm_y <= r6_n[1];
            r_out.norm_z <= r6_n[2];
            r_out.chosen_normal <= r6_idx;
        end
    end
    assign o_data = r_out;

endmodule
`default_nettype wire
